FILE: sv/urf_pkg.sv
package urf_pkg;

    // Event codes carried in the func field
    localparam logic [1:0] FUNC_SEND    = 2'd0;
    localparam logic [1:0] FUNC_MEASURE = 2'd1;
    localparam logic [1:0] FUNC_ECHO    = 2'd2;

    // Echo phase codes
    localparam logic [1:0] PH_WAIT    = 2'd0;
    localparam logic [1:0] PH_HIGH    = 2'd1;
    localparam logic [1:0] PH_DONE    = 2'd2;
    localparam logic [1:0] PH_TIMEOUT = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] CFG_TRIGGER_SKIP = 3'd0;
    localparam logic [2:0] CFG_TIMEOUT_US   = 3'd1;
    localparam logic [2:0] CFG_MAX_DIST     = 3'd2;
    localparam logic [2:0] CFG_MIN_VALID    = 3'd3;
    localparam logic [2:0] CFG_QUALIFY      = 3'd4;
    localparam logic [2:0] CFG_FLOOR_DIST   = 3'd5;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 16;

    // Reset values of the configuration registers
    localparam logic [7:0]  RST_TRIGGER_SKIP = 8'd4;
    localparam logic [15:0] RST_TIMEOUT_US   = 16'd6000;
    localparam logic [6:0]  RST_MAX_DIST     = 7'd102;
    localparam logic [6:0]  RST_MIN_VALID    = 7'd10;
    localparam logic [2:0]  RST_QUALIFY      = 3'd5;
    localparam logic [6:0]  RST_FLOOR_DIST   = 7'd2;

    // width*17/1000 == (width*CM_MUL) >> CM_SHIFT, exact for width < CM_LIMIT.
    // At or above CM_LIMIT the result is 128 or more and saturates.
    localparam int unsigned CM_LIMIT  = 7530;
    localparam int unsigned CM_IN_W   = 13;
    localparam int unsigned CM_MUL    = 18253614;
    localparam int unsigned CM_MUL_W  = 25;
    localparam int unsigned CM_SHIFT  = 30;
    localparam int unsigned CM_PROD_W = CM_IN_W + CM_MUL_W;

    typedef struct packed {
        logic [7:0]  trigger_skip;
        logic [15:0] timeout_us;
        logic [6:0]  max_distance;
        logic [6:0]  min_valid_distance;
        logic [2:0]  qualify_count;
        logic [6:0]  floor_distance;
    } t_cfg;

endpackage

FILE: sv/urf_req_if.sv
interface urf_req_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [23:0] now_us;

    modport source (output valid, output func, output now_us, input ready);
    modport sink   (input valid, input func, input now_us, output ready);
endinterface

FILE: sv/urf_rsp_if.sv
interface urf_rsp_if;
    logic       valid;
    logic       ready;
    logic       trigger_pulse;
    logic [6:0] distance_cm;
    logic [1:0] echo_phase;

    modport source (output valid, output trigger_pulse, output distance_cm,
                    output echo_phase, input ready);
    modport sink   (input valid, input trigger_pulse, input distance_cm,
                    input echo_phase, output ready);
endinterface

FILE: sv/urf_cfg_regs.sv
module urf_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [urf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urf_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    output urf_pkg::t_cfg                  o_cfg
);
    import urf_pkg::*;

    t_cfg r_cfg;

    // Register file; writes outside the list are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.trigger_skip       <= RST_TRIGGER_SKIP;
            r_cfg.timeout_us         <= RST_TIMEOUT_US;
            r_cfg.max_distance       <= RST_MAX_DIST;
            r_cfg.min_valid_distance <= RST_MIN_VALID;
            r_cfg.qualify_count      <= RST_QUALIFY;
            r_cfg.floor_distance     <= RST_FLOOR_DIST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_TRIGGER_SKIP: r_cfg.trigger_skip       <= i_cfg_wdata[7:0];
                CFG_TIMEOUT_US:   r_cfg.timeout_us         <= i_cfg_wdata;
                CFG_MAX_DIST:     r_cfg.max_distance       <= i_cfg_wdata[6:0];
                CFG_MIN_VALID:    r_cfg.min_valid_distance <= i_cfg_wdata[6:0];
                CFG_QUALIFY:      r_cfg.qualify_count      <= i_cfg_wdata[2:0];
                CFG_FLOOR_DIST:   r_cfg.floor_distance     <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;
endmodule

FILE: sv/urf_cm_conv.sv
module urf_cm_conv #(
    parameter int unsigned STAMP_BITS = 24
) (
    input  logic [STAMP_BITS-1:0] i_width,
    output logic [7:0]            o_raw_cm
);
    import urf_pkg::*;

    logic                 in_range;
    logic [CM_PROD_W-1:0] prod;

    // Reciprocal multiply; results of 128 and up saturate to 255, which
    // compares the same against any 7-bit limit
    assign in_range = (i_width < STAMP_BITS'(CM_LIMIT));
    assign prod     = CM_PROD_W'(i_width[CM_IN_W-1:0]) * CM_PROD_W'(CM_MUL);
    assign o_raw_cm = in_range ? {1'b0, prod[CM_SHIFT+6:CM_SHIFT]} : 8'hFF;
endmodule

FILE: sv/urf_core.sv
module urf_core #(
    parameter int unsigned STAMP_BITS = 24
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  urf_pkg::t_cfg i_cfg,
    input  logic          i_fire,
    input  logic [1:0]    i_func,
    input  logic [23:0]   i_now,
    output logic          o_trig,
    output logic [6:0]    o_dist,
    output logic [1:0]    o_phase
);
    import urf_pkg::*;

    logic [7:0]            r_send_cnt, n_send_cnt;
    logic [1:0]            r_phase, n_phase;
    logic [STAMP_BITS-1:0] r_echo_start, n_echo_start;
    logic [STAMP_BITS-1:0] r_echo_width, n_echo_width;
    logic [6:0]            r_dist, n_dist;
    logic [2:0]            r_run, n_run;

    logic [STAMP_BITS-1:0] now_s;
    logic [STAMP_BITS-1:0] elapsed;
    logic [7:0]            conv_cm;
    logic [7:0]            max8;
    logic [7:0]            raw;
    logic [7:0]            qual;
    logic [3:0]            run;
    logic                  trig;

    assign now_s   = STAMP_BITS'(i_now);
    assign elapsed = now_s - r_echo_start;
    assign max8    = {1'b0, i_cfg.max_distance};

    urf_cm_conv #(.STAMP_BITS(STAMP_BITS)) u_conv (
        .i_width  (r_echo_width),
        .o_raw_cm (conv_cm)
    );

    // Next state for one request
    always_comb begin
        n_send_cnt   = r_send_cnt;
        n_phase      = r_phase;
        n_echo_start = r_echo_start;
        n_echo_width = r_echo_width;
        n_dist       = r_dist;
        n_run        = r_run;
        trig         = 1'b0;
        raw          = {1'b0, r_dist};
        qual         = 8'd0;
        run          = 4'd0;
        case (i_func)
            FUNC_SEND: begin
                if (r_send_cnt > i_cfg.trigger_skip) begin
                    trig         = 1'b1;
                    n_phase      = PH_WAIT;
                    n_echo_width = '0;
                    n_send_cnt   = 8'd0;
                end else begin
                    n_send_cnt = r_send_cnt + 8'd1;
                end
            end
            FUNC_MEASURE: begin
                // raw reading
                if (r_phase == PH_DONE) begin
                    raw = conv_cm;
                end else if (r_phase == PH_HIGH &&
                             elapsed > STAMP_BITS'(i_cfg.timeout_us)) begin
                    n_phase = PH_TIMEOUT;
                    raw     = max8;
                end
                // qualification run
                if (raw < max8 && raw > {1'b0, i_cfg.min_valid_distance}) begin
                    run = {1'b0, r_run} + 4'd1;
                end
                if (run > {1'b0, i_cfg.qualify_count}) begin
                    n_run = i_cfg.qualify_count;
                    qual  = raw;
                end else begin
                    n_run = run[2:0];
                    qual  = max8;
                end
                // clamp, upper limit first
                if (qual > max8) begin
                    n_dist = i_cfg.max_distance;
                end else if (qual < {1'b0, i_cfg.floor_distance}) begin
                    n_dist = i_cfg.floor_distance;
                end else begin
                    n_dist = qual[6:0];
                end
            end
            FUNC_ECHO: begin
                if (r_phase == PH_WAIT) begin
                    n_echo_start = now_s;
                    n_phase      = PH_HIGH;
                end else if (r_phase == PH_HIGH) begin
                    n_echo_width = elapsed;
                    n_phase      = PH_DONE;
                end
            end
            default: ;
        endcase
    end

    // State update
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_send_cnt   <= 8'd0;
            r_phase      <= PH_WAIT;
            r_echo_start <= '0;
            r_echo_width <= '0;
            r_dist       <= 7'd0;
            r_run        <= 3'd0;
        end else if (i_fire) begin
            r_send_cnt   <= n_send_cnt;
            r_phase      <= n_phase;
            r_echo_start <= n_echo_start;
            r_echo_width <= n_echo_width;
            r_dist       <= n_dist;
            r_run        <= n_run;
        end
    end

    assign o_trig  = trig;
    assign o_dist  = n_dist;
    assign o_phase = n_phase;
endmodule

FILE: sv/ultrasonic_range_finder_unit.sv
// Ultrasonic ranger controller.
// i_req_ch carries one event per request: func (send tick, measure tick or
// echo edge) and now_us, a free-running microsecond stamp. o_rsp_ch returns
// exactly one result per request: trigger_pulse, distance_cm and echo_phase,
// in request order.
// Registers are written through i_cfg_we / i_cfg_idx / i_cfg_wdata while no
// request is in flight; the user must ensure this, as the block does not
// enforce it. They take effect on the next request. A request is held in the
// input register from acceptance; when it fires, the controller state updates
// and the result register loads. Throughput: one request per cycle while the
// receiver takes results, set by the update of the controller state, which
// each request reads and writes. When the receiver stalls, the result
// register holds and the input register still takes one more request;
// i_req_ch.ready drops only when both are full.
// Reset (synchronous, active low) clears the state and both pipeline valid
// flags and loads the register defaults; no clearing pass is needed.
module ultrasonic_range_finder_unit #(
    parameter int unsigned STAMP_BITS = 24
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    urf_req_if.sink                        i_req_ch,
    urf_rsp_if.source                      o_rsp_ch,
    input  logic                           i_cfg_we,
    input  logic [urf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [urf_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import urf_pkg::*;

    t_cfg        cfg;
    logic        r_in_valid;
    logic [1:0]  r_func;
    logic [23:0] r_now;
    logic        r_out_valid;
    logic        r_trig;
    logic [6:0]  r_dist;
    logic [1:0]  r_phase;

    logic        advance;
    logic        fire;
    logic        accept;
    logic        n_trig;
    logic [6:0]  n_dist;
    logic [1:0]  n_phase;

    urf_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // Handshake control
    assign advance        = !r_out_valid || o_rsp_ch.ready;
    assign fire           = r_in_valid && advance;
    assign i_req_ch.ready = !r_in_valid || advance;
    assign accept         = i_req_ch.valid && i_req_ch.ready;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_func <= i_req_ch.func;
            r_now  <= i_req_ch.now_us;
        end
    end

    urf_core #(.STAMP_BITS(STAMP_BITS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_fire  (fire),
        .i_func  (r_func),
        .i_now   (r_now),
        .o_trig  (n_trig),
        .o_dist  (n_dist),
        .o_phase (n_phase)
    );

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (fire) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp_ch.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_trig  <= n_trig;
            r_dist  <= n_dist;
            r_phase <= n_phase;
        end
    end

    assign o_rsp_ch.valid         = r_out_valid;
    assign o_rsp_ch.trigger_pulse = r_trig;
    assign o_rsp_ch.distance_cm   = r_dist;
    assign o_rsp_ch.echo_phase    = r_phase;
endmodule

FILE: test/tb_ultrasonic_range_finder_unit.sv
`timescale 1ns / 100ps

module tb_ultrasonic_range_finder_unit;
    import urf_pkg::*;

    // func value that no event uses; the block must leave its state alone
    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam int         STALL_LIMIT = 1000;
    localparam int         ITEM_TARGET = 950;

    typedef struct packed {
        logic [1:0]  func;
        logic [23:0] now_us;
    } t_range_evt;

    typedef struct packed {
        logic       trigger_pulse;
        logic [6:0] distance_cm;
        logic [1:0] echo_phase;
    } t_range_res;

    logic i_clk;
    logic i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_idx;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    urf_req_if req_ch ();
    urf_rsp_if rsp_ch ();

    ultrasonic_range_finder_unit #(
        .STAMP_BITS (24)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_ch    (req_ch),
        .o_rsp_ch    (rsp_ch),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_wdata (cfg_wdata)
    );

    // Requests waiting to be driven and results still owed by the block
    t_range_evt evt_pending_q[$];
    t_range_res range_exp_q[$];

    // Ranger state as the checker sees it
    t_cfg        cfg_model;
    logic [7:0]  rng_send_cnt;
    logic [1:0]  rng_phase;
    logic [23:0] rng_start;
    logic [23:0] rng_width;
    logic [6:0]  rng_dist;
    logic [2:0]  rng_run;

    // Stimulus bookkeeping
    int          gen_items    = 0;
    logic [7:0]  gen_send_cnt = 8'd0;
    int          seq_target   = 40;
    int          err_count    = 0;
    int          rsp_count    = 0;
    int          hold_left    = 0;
    int          cyc_count    = 0;
    int          stall_cycles = 0;
    logic        calm;

    // No idling on either side in the upper part of each repeating cyc_count window
    assign calm = (cyc_count % 1024) >= 700;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // One event through the ranger; returns the result the block must report
    function automatic t_range_res step_ranger(input t_range_evt ev);
        t_range_res  res;
        logic [63:0] raw;
        logic [3:0]  run;
        logic [23:0] elapsed;
        res.trigger_pulse = 1'b0;
        case (ev.func)
            FUNC_SEND: begin
                if (rng_send_cnt > cfg_model.trigger_skip) begin
                    res.trigger_pulse = 1'b1;
                    rng_phase    = PH_WAIT;
                    rng_width    = '0;
                    rng_send_cnt = '0;
                end else begin
                    rng_send_cnt = rng_send_cnt + 8'd1;
                end
            end
            FUNC_MEASURE: begin
                raw = 64'(rng_dist);
                if (rng_phase == PH_DONE) begin
                    raw = (64'(rng_width) * 64'd17) / 64'd1000;
                end else if (rng_phase == PH_HIGH) begin
                    elapsed = ev.now_us - rng_start;
                    if (elapsed > 24'(cfg_model.timeout_us)) begin
                        rng_phase = PH_TIMEOUT;
                        raw = 64'(cfg_model.max_distance);
                    end
                end
                // qualification run
                if (raw < 64'(cfg_model.max_distance) &&
                    raw > 64'(cfg_model.min_valid_distance))
                    run = {1'b0, rng_run} + 4'd1;
                else
                    run = 4'd0;
                if (run > {1'b0, cfg_model.qualify_count}) begin
                    rng_run = cfg_model.qualify_count;
                end else begin
                    rng_run = run[2:0];
                    raw = 64'(cfg_model.max_distance);
                end
                // clamp; upper bound checked first so a high floor wins
                if (raw > 64'(cfg_model.max_distance))
                    raw = 64'(cfg_model.max_distance);
                else if (raw < 64'(cfg_model.floor_distance))
                    raw = 64'(cfg_model.floor_distance);
                rng_dist = raw[6:0];
            end
            FUNC_ECHO: begin
                if (rng_phase == PH_WAIT) begin
                    rng_start = ev.now_us;
                    rng_phase = PH_HIGH;
                end else if (rng_phase == PH_HIGH) begin
                    rng_width = ev.now_us - rng_start;
                    rng_phase = PH_DONE;
                end
            end
            default: ;
        endcase
        res.distance_cm = rng_dist;
        res.echo_phase  = rng_phase;
        return res;
    endfunction

    // Queue one request; track the send counter so trigger sequences land
    task automatic push_evt(input logic [1:0] func, input logic [23:0] stamp);
        t_range_evt ev;
        ev.func   = func;
        ev.now_us = stamp;
        evt_pending_q.push_back(ev);
        gen_items++;
        if (func == FUNC_SEND) begin
            if (gen_send_cnt > cfg_model.trigger_skip)
                gen_send_cnt = 8'd0;
            else
                gen_send_cnt = gen_send_cnt + 8'd1;
        end
    endtask

    // Send ticks up to and including the one that fires (a few if it never can)
    task automatic fire_trigger();
        int n;
        if (cfg_model.trigger_skip == 8'd255)
            n = $urandom_range(1, 3);
        else if (gen_send_cnt > cfg_model.trigger_skip)
            n = 1;
        else
            n = int'(cfg_model.trigger_skip) + 2 - int'(gen_send_cnt);
        repeat (n) push_evt(FUNC_SEND, 24'($urandom));
    endtask

    // One random sequence: mostly complete measurements, some timeouts, some noise
    task automatic add_sequence();
        int          kind;
        int          n;
        int          lo;
        int          hi;
        logic [23:0] t0;
        logic [23:0] width;
        logic [23:0] elapsed;
        kind = $urandom_range(0, 99);
        t0   = 24'($urandom);
        lo   = int'(cfg_model.min_valid_distance) + 1;
        hi   = int'(cfg_model.max_distance) - 1;
        // distance target is sticky so qualification runs can build up
        if ($urandom_range(0, 4) == 0) begin
            if (lo <= hi && $urandom_range(0, 4) != 0)
                seq_target = $urandom_range(lo, hi);
            else
                seq_target = $urandom_range(0, 130);
        end
        if ($urandom_range(0, 19) == 0)
            width = 24'($urandom);
        else
            width = 24'(seq_target * 59 + $urandom_range(0, 58));

        if (kind < 60) begin
            // trigger, echo rise and fall, then conversions
            fire_trigger();
            push_evt(FUNC_ECHO, t0);
            push_evt(FUNC_ECHO, t0 + width);
            n = $urandom_range(1, 3);
            repeat (n) push_evt(FUNC_MEASURE, 24'($urandom));
        end else if (kind < 75) begin
            // echo stays high up to a measure around the timeout boundary
            fire_trigger();
            push_evt(FUNC_ECHO, t0);
            case ($urandom_range(0, 3))
                0:       elapsed = 24'(cfg_model.timeout_us) - 24'd1;
                1:       elapsed = 24'(cfg_model.timeout_us);
                2:       elapsed = 24'(cfg_model.timeout_us) + 24'd1;
                default: elapsed = 24'($urandom);
            endcase
            push_evt(FUNC_MEASURE, t0 + elapsed);
            if ($urandom_range(0, 1) == 1)
                push_evt(FUNC_ECHO, 24'($urandom));
            push_evt(FUNC_MEASURE, 24'($urandom));
        end else if (kind < 85) begin
            // conversion while echo is still high, then the echo falls
            fire_trigger();
            push_evt(FUNC_ECHO, t0);
            push_evt(FUNC_MEASURE,
                     t0 + 24'($urandom_range(0, int'(cfg_model.timeout_us))));
            push_evt(FUNC_ECHO, t0 + width);
            push_evt(FUNC_MEASURE, 24'($urandom));
        end else begin
            // noise, unused selector included
            n = $urandom_range(1, 4);
            repeat (n) push_evt(2'($urandom_range(0, 3)), 24'($urandom));
        end
    endtask

    // Wait until every request is accepted and every result has come back
    task automatic wait_drain();
        while (evt_pending_q.size() != 0 || req_ch.valid || range_exp_q.size() != 0 ||
               rsp_count != gen_items)
            @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int value);
        @(posedge i_clk);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= CFG_DATA_W'(value);
        @(posedge i_clk);
        cfg_we    <= 1'b0;
        case (idx)
            CFG_TRIGGER_SKIP: cfg_model.trigger_skip       = 8'(value);
            CFG_TIMEOUT_US:   cfg_model.timeout_us         = 16'(value);
            CFG_MAX_DIST:     cfg_model.max_distance       = 7'(value);
            CFG_MIN_VALID:    cfg_model.min_valid_distance = 7'(value);
            CFG_QUALIFY:      cfg_model.qualify_count      = 3'(value);
            CFG_FLOOR_DIST:   cfg_model.floor_distance     = 7'(value);
            default: ;
        endcase
    endtask

    task automatic apply_cfg(input int skip, input int tmo, input int dmax,
                             input int dmin, input int qual, input int dfloor);
        write_reg(CFG_TRIGGER_SKIP, skip);
        write_reg(CFG_TIMEOUT_US, tmo);
        write_reg(CFG_MAX_DIST, dmax);
        write_reg(CFG_MIN_VALID, dmin);
        write_reg(CFG_QUALIFY, qual);
        write_reg(CFG_FLOOR_DIST, dfloor);
    endtask

    // Request driver: predicts on acceptance, then offers the next pending item
    always @(posedge i_clk) begin : drv_blk
        t_range_evt ev;
        if (!i_rst_n) begin
            req_ch.valid <= 1'b0;
            cfg_model.trigger_skip       = RST_TRIGGER_SKIP;
            cfg_model.timeout_us         = RST_TIMEOUT_US;
            cfg_model.max_distance       = RST_MAX_DIST;
            cfg_model.min_valid_distance = RST_MIN_VALID;
            cfg_model.qualify_count      = RST_QUALIFY;
            cfg_model.floor_distance     = RST_FLOOR_DIST;
            rng_send_cnt = '0;
            rng_phase    = PH_WAIT;
            rng_start    = '0;
            rng_width    = '0;
            rng_dist     = '0;
            rng_run      = '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                ev.func   = req_ch.func;
                ev.now_us = req_ch.now_us;
                range_exp_q.push_back(step_ranger(ev));
            end
            if (!req_ch.valid || req_ch.ready) begin
                if (evt_pending_q.size() != 0 && (calm || $urandom_range(0, 99) >= 16)) begin
                    ev = evt_pending_q.pop_front();
                    req_ch.valid  <= 1'b1;
                    req_ch.func   <= ev.func;
                    req_ch.now_us <= ev.now_us;
                end else begin
                    req_ch.valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare against the oldest expectation, drive ready
    always @(posedge i_clk) begin : mon_blk
        t_range_res exp_res;
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
            hold_left = 0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_count++;
                if (range_exp_q.size() == 0) begin
                    $error("unexpected result: distance_cm %0d echo_phase %0d",
                           rsp_ch.distance_cm, rsp_ch.echo_phase);
                    err_count++;
                end else begin
                    exp_res = range_exp_q.pop_front();
                    if (rsp_ch.trigger_pulse !== exp_res.trigger_pulse) begin
                        $error("trigger_pulse: expected %0d, got %0d",
                               exp_res.trigger_pulse, rsp_ch.trigger_pulse);
                        err_count++;
                    end
                    if (rsp_ch.distance_cm !== exp_res.distance_cm) begin
                        $error("distance_cm: expected %0d, got %0d",
                               exp_res.distance_cm, rsp_ch.distance_cm);
                        err_count++;
                    end
                    if (rsp_ch.echo_phase !== exp_res.echo_phase) begin
                        $error("echo_phase: expected %0d, got %0d",
                               exp_res.echo_phase, rsp_ch.echo_phase);
                        err_count++;
                    end
                end
                // long back-pressure now and then so the input side fills up
                if (rsp_count % 250 == 100)
                    hold_left = 60;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= calm || ($urandom_range(0, 99) >= 16);
            end
        end
    end

    // Watchdog on cycles with no request or result moving
    always @(posedge i_clk) begin
        cyc_count <= cyc_count + 1;
        if (!i_rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        int r_skip;
        int r_tmo;
        int r_max;
        int r_min;
        int r_floor;
        int phase_end;
        req_ch.valid  = 1'b0;
        req_ch.func   = FUNC_SEND;
        req_ch.now_us = '0;
        rsp_ch.ready  = 1'b0;
        cfg_we        = 1'b0;
        cfg_idx       = CFG_TRIGGER_SKIP;
        cfg_wdata     = '0;
        i_rst_n       = 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed part at reset defaults
        push_evt(FUNC_UNUSED, 24'hFFFFFF);
        push_evt(FUNC_MEASURE, 24'h000000);
        push_evt(FUNC_ECHO, 24'hFFFF00);   // echo starts just below the wrap
        push_evt(FUNC_ECHO, 24'h000100);   // width taken across the wrap
        push_evt(FUNC_ECHO, 24'h000000);   // ignored once measured
        push_evt(FUNC_MEASURE, 24'h123456);
        fire_trigger();
        push_evt(FUNC_ECHO, 24'h000000);
        push_evt(FUNC_MEASURE, 24'd6000);  // exactly at the timeout: still high
        push_evt(FUNC_MEASURE, 24'd6001);  // one past: timed out
        push_evt(FUNC_ECHO, 24'h000010);   // ignored after timeout
        push_evt(FUNC_MEASURE, 24'h000000);
        fire_trigger();
        push_evt(FUNC_ECHO, 24'h000001);
        push_evt(FUNC_ECHO, 24'h000000);   // widest possible pulse
        push_evt(FUNC_MEASURE, 24'hABCDEF);
        wait_drain();

        // Fixed extremes first, then random settings
        for (int p = 0; gen_items < ITEM_TARGET; p++) begin
            case (p)
                0: apply_cfg(0, 65535, 127, 0, 7, 0);
                1: apply_cfg(1, 1, 2, 127, 0, 127);     // floor above the maximum
                2: apply_cfg(255, 300, 60, 20, 3, 5);   // trigger never fires
                3: apply_cfg(0, 6000, 102, 10, 0, 2);
                4: apply_cfg(37, 9000, 90, 15, 2, 4);
                default: begin
                    r_skip = ($urandom_range(0, 4) == 0) ? $urandom_range(4, 20)
                                                         : $urandom_range(0, 3);
                    case ($urandom_range(0, 2))
                        0:       r_tmo = $urandom_range(1, 200);
                        1:       r_tmo = $urandom_range(2000, 9000);
                        default: r_tmo = $urandom_range(1, 65535);
                    endcase
                    r_max   = $urandom_range(2, 127);
                    r_min   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(0, r_max - 1);
                    r_floor = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127)
                                                          : $urandom_range(0, 15);
                    apply_cfg(r_skip, r_tmo, r_max, r_min, $urandom_range(0, 7), r_floor);
                end
            endcase
            phase_end = gen_items + ((p == 2) ? 40 : 110);
            while (gen_items < phase_end)
                add_sequence();
            wait_drain();
        end

        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

FILE: sim.f
sv/urf_pkg.sv
sv/urf_req_if.sv
sv/urf_rsp_if.sv
sv/urf_cfg_regs.sv
sv/urf_cm_conv.sv
sv/urf_core.sv
sv/ultrasonic_range_finder_unit.sv
test/tb_ultrasonic_range_finder_unit.sv
